### rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the streaming find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

    // Widths of the text and register fields
    localparam int BYTE_W     = 8;
    localparam int WORD_W     = 64;
    localparam int LEN_W      = 4;
    localparam int CFG_IDX_W  = 8;

    // Default pattern window depth
    localparam int MAX_PATTERN_DEF = 8;

    // Result burst buffer: one item yields at most this many results
    localparam int BURST_DEPTH = 8;
    localparam int BURST_LEN_W = 4;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES      = 8'd0,
        CFG_PATTERN_LENGTH     = 8'd1,
        CFG_REPLACEMENT_BYTES  = 8'd2,
        CFG_REPLACEMENT_LENGTH = 8'd3
    } cfg_index_t;

    // Results of one input item, handed from the window to the output buffer
    typedef struct packed {
        logic [BURST_DEPTH-1:0][BYTE_W-1:0] data;
        logic [BURST_LEN_W-1:0]             len;   // zero: no result
        logic                               last;  // final item of the text
        logic                               bare;  // lone end marker
    } burst_t;

endpackage

### rtl/sfr_in_if.sv
// ----------------------------------------------------------------------------
// sfr_in_if
// Input text channel: one byte or end marker per transfer.
// ----------------------------------------------------------------------------
interface sfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       byte_present;
    logic       end_of_text;

    modport source (output valid, output text_byte, output byte_present,
                    output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input byte_present,
                    input end_of_text, output ready);
endinterface

### rtl/sfr_out_if.sv
// ----------------------------------------------------------------------------
// sfr_out_if
// Output text channel: one rewritten byte or end marker per transfer.
// ----------------------------------------------------------------------------
interface sfr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_present;
    logic       out_last;

    modport source (output valid, output out_byte, output out_present,
                    output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_present,
                    input out_last, output ready);
endinterface

### rtl/sfr_cfg_if.sv
// ----------------------------------------------------------------------------
// sfr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface sfr_cfg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/sfr_window.sv
// ----------------------------------------------------------------------------
// sfr_window
// Configuration registers and pending window. Decides every accepted item
// combinationally, in the cycle it is accepted: parallel compare against the
// pattern, then builds the burst of results for that item.
// ----------------------------------------------------------------------------
module sfr_window
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    sfr_cfg_if.sink           cfg,
    input  logic              accept,
    input  logic [BYTE_W-1:0] text_byte,
    input  logic              byte_present,
    input  logic              end_of_text,
    output burst_t            burst
);

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);

    logic [WORD_W-1:0] pattern_bytes_reg, pattern_bytes_next;
    logic [LEN_W-1:0]  pattern_length_reg, pattern_length_next;
    logic [WORD_W-1:0] replacement_bytes_reg, replacement_bytes_next;
    logic [LEN_W-1:0]  replacement_length_reg, replacement_length_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_reg, window_next;

    logic [CNT_W-1:0]       plen;
    logic [BURST_LEN_W-1:0] rlen;
    logic [CNT_W-1:0]       cnt;
    logic [CNT_W-1:0]       cnt1;
    logic                   full;
    logic                   match;
    logic                   cfg_write;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_ins;
    logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_shift;
    logic [BURST_DEPTH-1:0][BYTE_W-1:0] seq_ins;
    logic [BURST_DEPTH-1:0][BYTE_W-1:0] seq_win;
    logic [BURST_DEPTH-1:0][BYTE_W-1:0] seq;
    logic [BURST_LEN_W-1:0] seq_len;

    assign cfg.ready = 1'b1;
    assign cfg_write = cfg.valid && cfg.ready;

    // Active lengths, clamped to the hardware limits
    always_comb
    begin
        if (pattern_length_reg > LEN_W'(MAX_PATTERN))
            plen = CNT_W'(MAX_PATTERN);
        else
            plen = CNT_W'(pattern_length_reg);
        if (replacement_length_reg > LEN_W'(BURST_DEPTH))
            rlen = BURST_LEN_W'(BURST_DEPTH);
        else
            rlen = BURST_LEN_W'(replacement_length_reg);
    end

    // Window with the new byte written at the fill position, and compare
    always_comb
    begin
        cnt   = (count_reg >= plen) ? '0 : count_reg;
        cnt1  = cnt + 1'b1;
        full  = (cnt1 == plen);
        match = 1'b1;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            win_ins[k] = (CNT_W'(k) == cnt) ? text_byte : window_reg[k];
            if ((CNT_W'(k) < plen) && (win_ins[k] != pattern_bytes_reg[k*BYTE_W +: BYTE_W]))
                match = 1'b0;
        end
        for (int k = 0; k < MAX_PATTERN - 1; k++)
            win_shift[k] = win_ins[k+1];
        win_shift[MAX_PATTERN-1] = '0;
        seq_ins = '0;
        seq_win = '0;
        for (int k = 0; k < MAX_PATTERN; k++)
        begin
            seq_ins[k] = win_ins[k];
            seq_win[k] = window_reg[k];
        end
    end

    // Results of this item and next window state
    always_comb
    begin
        pattern_bytes_next      = pattern_bytes_reg;
        pattern_length_next     = pattern_length_reg;
        replacement_bytes_next  = replacement_bytes_reg;
        replacement_length_next = replacement_length_reg;
        window_next             = window_reg;
        count_next              = count_reg;
        seq                     = seq_win;
        seq_len                 = '0;

        if (byte_present)
        begin
            if (plen == '0)
            begin
                // pass through
                seq     = '0;
                seq[0]  = text_byte;
                seq_len = BURST_LEN_W'(1);
            end
            else if (full && match)
            begin
                seq        = replacement_bytes_reg;
                seq_len    = rlen;
                count_next = '0;
            end
            else if (full)
            begin
                // oldest byte leaves; on end of text the whole window flushes
                seq         = seq_ins;
                seq_len     = end_of_text ? BURST_LEN_W'(plen) : BURST_LEN_W'(1);
                window_next = win_shift;
                count_next  = plen - 1'b1;
            end
            else
            begin
                seq         = seq_ins;
                seq_len     = end_of_text ? BURST_LEN_W'(cnt1) : '0;
                window_next = win_ins;
                count_next  = cnt1;
            end
        end
        else
        begin
            seq     = seq_win;
            seq_len = end_of_text ? BURST_LEN_W'(cnt) : '0;
        end

        if (end_of_text)
            count_next = '0;

        if (!accept)
        begin
            window_next = window_reg;
            count_next  = count_reg;
        end

        burst.data = seq;
        burst.len  = seq_len;
        burst.last = end_of_text;
        burst.bare = 1'b0;
        if (end_of_text && (seq_len == '0))
        begin
            burst.data = '0;
            burst.len  = BURST_LEN_W'(1);
            burst.bare = 1'b1;
        end

        // register writes; a new pattern length drops the window
        if (cfg_write)
        begin
            case (cfg.index)
                CFG_PATTERN_BYTES:
                    pattern_bytes_next = cfg.data;
                CFG_PATTERN_LENGTH:
                begin
                    pattern_length_next = cfg.data[LEN_W-1:0];
                    count_next          = '0;
                end
                CFG_REPLACEMENT_BYTES:
                    replacement_bytes_next = cfg.data;
                CFG_REPLACEMENT_LENGTH:
                    replacement_length_next = cfg.data[LEN_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_bytes_reg      <= '0;
            pattern_length_reg     <= '0;
            replacement_bytes_reg  <= '0;
            replacement_length_reg <= '0;
            count_reg              <= '0;
        end
        else
        begin
            pattern_bytes_reg      <= pattern_bytes_next;
            pattern_length_reg     <= pattern_length_next;
            replacement_bytes_reg  <= replacement_bytes_next;
            replacement_length_reg <= replacement_length_next;
            count_reg              <= count_next;
        end
    end

    // Window bytes, no reset
    always_ff @(posedge clk)
    begin
        window_reg <= window_next;
    end

endmodule

### rtl/sfr_burst.sv
// ----------------------------------------------------------------------------
// sfr_burst
// Output register holding the results of one item; hands them out one per
// transfer, oldest first, and frees itself during its final transfer.
// ----------------------------------------------------------------------------
module sfr_burst
    import sfr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  burst_t   burst,
    output logic     load_ready,
    sfr_out_if.source out
);

    logic [BURST_DEPTH-1:0][BYTE_W-1:0] data_reg, data_next;
    logic [BURST_LEN_W-1:0]             remain_reg, remain_next;
    logic                               last_reg, last_next;
    logic                               bare_reg, bare_next;
    logic                               take;

    // Output side
    assign out.valid       = (remain_reg != '0);
    assign out.out_byte    = data_reg[0];
    assign out.out_present = !bare_reg;
    assign out.out_last    = last_reg && (remain_reg == BURST_LEN_W'(1));
    assign take            = out.valid && out.ready;

    // Free when empty or when the final result leaves now
    assign load_ready = (remain_reg == '0) ||
                        ((remain_reg == BURST_LEN_W'(1)) && out.ready);

    // Load a new burst or shift the current one
    always_comb
    begin
        data_next   = data_reg;
        remain_next = remain_reg;
        last_next   = last_reg;
        bare_next   = bare_reg;
        if (load)
        begin
            data_next   = burst.data;
            remain_next = burst.len;
            last_next   = burst.last;
            bare_next   = burst.bare;
        end
        else if (take)
        begin
            for (int k = 0; k < BURST_DEPTH - 1; k++)
                data_next[k] = data_reg[k+1];
            data_next[BURST_DEPTH-1] = '0;
            remain_next = remain_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            remain_reg <= '0;
        else
            remain_reg <= remain_next;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        last_reg <= last_next;
        bare_reg <= bare_next;
    end

endmodule

### rtl/stream_find_and_replace.sv
// ----------------------------------------------------------------------------
// stream_find_and_replace
// Streaming substring find-and-replace over a byte text.
// ----------------------------------------------------------------------------
// Each accepted item is decided in the cycle it is accepted: the new byte is
// written into the pending window, all window bytes are compared with the
// pattern in parallel, and the item's results (up to eight) land in an output
// register that hands out one result per transfer. An item that yields zero
// or one result does not hold the input, so one byte per cycle flows while
// the sink is ready; an item yielding more results holds the input until
// they drain, the next item being accepted during the last transfer. The
// rate is set by the single output port draining that result register.
// Config writes are always accepted; writing pattern_length empties the window.
// ----------------------------------------------------------------------------
module stream_find_and_replace
    import sfr_pkg::*;
#(
    parameter int MAX_PATTERN = MAX_PATTERN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    sfr_in_if.sink     text_in,
    sfr_out_if.source  text_out,
    sfr_cfg_if.sink    cfg
);

    burst_t burst;
    logic   load_ready;
    logic   accept;

    // Input transfer
    assign text_in.ready = load_ready;
    assign accept        = text_in.valid && load_ready;

    sfr_window #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .accept       (accept),
        .text_byte    (text_in.text_byte),
        .byte_present (text_in.byte_present),
        .end_of_text  (text_in.end_of_text),
        .burst        (burst)
    );

    // Every accepted item loads its results; an empty burst leaves the register free
    sfr_burst u_burst (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept),
        .burst      (burst),
        .load_ready (load_ready),
        .out        (text_out)
    );

endmodule
